FILE: rtl/class_score_window_vote_assert.svh
// assertion macros for the class score window vote block
`ifndef CLASS_SCORE_WINDOW_VOTE_ASSERT_SVH
`define CLASS_SCORE_WINDOW_VOTE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csw assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csw assertion failed");

`endif

FILE: rtl/csw_pkg.sv
// shared types and constants for the class score window vote block
package csw_pkg;

    localparam int CLASS_COUNT = 9;
    localparam int SCORE_W     = 8;
    localparam int DIFF_W      = 9;
    localparam int SCALE_W     = 16;
    localparam int LEVEL_W     = 16;
    localparam int WIN_W       = 4;
    localparam int CLASS_W     = 4;
    localparam int AVG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 2'd3;

    localparam logic signed [SCORE_W-1:0] OFFSET_RESET = -8'sd128;
    localparam logic [SCALE_W-1:0]        SCALE_RESET  = 16'd256;
    localparam logic [WIN_W-1:0]          WINDOW_RESET = 4'd10;
    localparam logic [LEVEL_W-1:0]        LEVEL_RESET  = 16'd39322;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef diff_t [CLASS_COUNT-1:0]  diff_vec_t;

    typedef struct packed {
        logic push;
        logic rotate;
    } cell_ctrl_t;

    typedef struct packed {
        logic acc_clear;
        logic acc_en;
        logic start;
    } vote_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [CLASS_W-1:0] best_class;
        logic               uncertain;
        logic [AVG_W-1:0]   best_average;
    } vote_res_t;

endpackage

FILE: rtl/csw_cell.sv
// one history slot holding the offset-corrected scores of all classes
module csw_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  csw_pkg::cell_ctrl_t   ctrl,
    input  csw_pkg::diff_vec_t    push_in,
    input  csw_pkg::diff_vec_t    rot_in,
    output csw_pkg::diff_vec_t    data
);

    csw_pkg::diff_vec_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            priority if (ctrl.push)
            begin
                data_reg <= push_in;
            end
            else if (ctrl.rotate)
            begin
                data_reg <= rot_in;
            end
        end
    end

    assign data = data_reg;

endmodule

FILE: rtl/csw_vote.sv
// window sums, scaled argmax scan, threshold test and serial divide by window length
module csw_vote #(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  csw_pkg::vote_ctrl_t                ctrl,
    input  csw_pkg::diff_vec_t                 acc_data,
    input  logic [$clog2(HISTORY_DEPTH+1)-1:0] n_eff,
    input  logic [csw_pkg::SCALE_W-1:0]        scale,
    input  logic [csw_pkg::LEVEL_W-1:0]        level,
    output csw_pkg::vote_res_t                 res
);

    localparam int NW     = $clog2(HISTORY_DEPTH+1);
    localparam int SUM_W  = csw_pkg::DIFF_W + $clog2(HISTORY_DEPTH);
    localparam int P_W    = SUM_W + csw_pkg::SCALE_W + 1;
    localparam int REM_W  = NW + csw_pkg::AVG_W;
    localparam int LN_W   = csw_pkg::LEVEL_W + NW;
    localparam int CNT_W  = $clog2(csw_pkg::CLASS_COUNT+1);
    localparam int STEP_W = $clog2(csw_pkg::AVG_W);
    localparam int AVG_W  = csw_pkg::AVG_W;
    localparam int CLASS_W = csw_pkg::CLASS_W;

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_SCAN = 3'd1;
    localparam logic [2:0] P_PREP = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_DONE = 3'd4;

    localparam logic [CNT_W-1:0]   CNT_END    = CNT_W'(csw_pkg::CLASS_COUNT);
    localparam logic [CLASS_W-1:0] LAST_CLASS = CLASS_W'(csw_pkg::CLASS_COUNT - 1);

    logic [2:0]               phase_reg;
    logic [CNT_W-1:0]         issue_reg;
    logic                     pv_reg;
    logic [STEP_W-1:0]        step_reg;

    logic signed [SUM_W-1:0]  sum_reg [csw_pkg::CLASS_COUNT];
    logic signed [P_W-1:0]    prod_reg;
    logic [CLASS_W-1:0]       pidx_reg;
    logic signed [P_W-1:0]    best_p_reg;
    logic [CLASS_W-1:0]       best_idx_reg;
    logic [LN_W-1:0]          lvl_n_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [REM_W-1:0]         div_reg;
    logic [AVG_W-1:0]         q_reg;
    logic                     unc_reg;
    logic [AVG_W-1:0]         avg_reg;

    logic                     issue_ok;
    logic signed [SUM_W-1:0]  sum_sel;
    logic signed [P_W-1:0]    lvl_n_ext;
    logic signed [P_W-1:0]    sat_ext;
    logic                     p_nonpos;
    logic                     p_sat;
    logic                     ge;
    logic [AVG_W-1:0]         q_next;

    assign issue_ok  = issue_reg < CNT_END;
    assign sum_sel   = sum_reg[issue_reg[CLASS_W-1:0]];
    assign lvl_n_ext = $signed({{(P_W-LN_W){1'b0}}, lvl_n_reg});
    assign sat_ext   = $signed({{(P_W-REM_W){1'b0}}, n_eff, {AVG_W{1'b0}}});
    assign p_nonpos  = best_p_reg <= $signed({P_W{1'b0}});
    assign p_sat     = best_p_reg >= sat_ext;
    assign ge        = rem_reg >= div_reg;
    assign q_next    = {q_reg[AVG_W-2:0], ge};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            issue_reg <= '0;
            pv_reg    <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (phase_reg)
                P_IDLE, P_DONE:
                begin
                    if (ctrl.start)
                    begin
                        phase_reg <= P_SCAN;
                        issue_reg <= '0;
                        pv_reg    <= 1'b0;
                    end
                end
                P_SCAN:
                begin
                    pv_reg <= issue_ok;
                    if (issue_ok)
                    begin
                        issue_reg <= issue_reg + CNT_W'(1);
                    end
                    if (pv_reg && pidx_reg == LAST_CLASS)
                    begin
                        phase_reg <= P_PREP;
                    end
                end
                P_PREP:
                begin
                    step_reg <= STEP_W'(AVG_W - 1);
                    if (p_nonpos || p_sat)
                    begin
                        phase_reg <= P_DONE;
                    end
                    else
                    begin
                        phase_reg <= P_DIV;
                    end
                end
                P_DIV:
                begin
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == '0)
                    begin
                        phase_reg <= P_DONE;
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    // window sums
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < csw_pkg::CLASS_COUNT; c++)
        begin
            priority if (ctrl.acc_clear)
            begin
                sum_reg[c] <= '0;
            end
            else if (ctrl.acc_en)
            begin
                sum_reg[c] <= sum_reg[c] + SUM_W'($signed(acc_data[c]));
            end
        end
    end

    // scan, threshold and divide datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            lvl_n_reg <= LN_W'(level) * LN_W'(n_eff);
        end
        if (phase_reg == P_SCAN)
        begin
            if (issue_ok)
            begin
                prod_reg <= P_W'(sum_sel) * P_W'($signed({1'b0, scale}));
                pidx_reg <= issue_reg[CLASS_W-1:0];
            end
            if (pv_reg && (pidx_reg == '0 || prod_reg > best_p_reg))
            begin
                best_p_reg   <= prod_reg;
                best_idx_reg <= pidx_reg;
            end
        end
        if (phase_reg == P_PREP)
        begin
            unc_reg <= !(best_p_reg > lvl_n_ext);
            rem_reg <= best_p_reg[REM_W-1:0];
            div_reg <= REM_W'({n_eff, {(AVG_W-1){1'b0}}});
            q_reg   <= '0;
            priority if (p_nonpos)
            begin
                avg_reg <= '0;
            end
            else if (p_sat)
            begin
                avg_reg <= {AVG_W{1'b1}};
            end
        end
        if (phase_reg == P_DIV)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - div_reg;
            end
            div_reg <= div_reg >> 1;
            q_reg   <= q_next;
            if (step_reg == '0)
            begin
                avg_reg <= q_next;
            end
        end
    end

    assign res.done         = phase_reg == P_DONE;
    assign res.best_class   = best_idx_reg;
    assign res.uncertain    = unc_reg;
    assign res.best_average = avg_reg;

endmodule

FILE: rtl/class_score_window_vote.sv
// top level: ring of history cells, window vote unit and output register
//
//   channel  | signals                                   | beat when
//   ---------+-------------------------------------------+----------------------
//   input    | in_valid, in_ready, score_0 .. score_8    | in_valid & in_ready
//   output   | out_valid, out_ready, best_class,         | out_valid & out_ready
//            | uncertain, best_average                   |
//   config   | cfg_we, cfg_index, cfg_data               | cfg_we
//
// one input beat runs through the push, one full turn of the cell ring, a scan over
// nine classes, a setup step, a 16-step divide and a load
// an average that clamps to 0 or 65535 skips the divide
// the next beat is taken once the result sits in the output register
// a stalled result holds the block after its next item's vote is finished
// reset clears the history cells to zero at once and loads register defaults
module class_score_window_vote #(
    parameter int HISTORY_DEPTH = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [csw_pkg::SCORE_W-1:0]  score_0,
    input  logic signed [csw_pkg::SCORE_W-1:0]  score_1,
    input  logic signed [csw_pkg::SCORE_W-1:0]  score_2,
    input  logic signed [csw_pkg::SCORE_W-1:0]  score_3,
    input  logic signed [csw_pkg::SCORE_W-1:0]  score_4,
    input  logic signed [csw_pkg::SCORE_W-1:0]  score_5,
    input  logic signed [csw_pkg::SCORE_W-1:0]  score_6,
    input  logic signed [csw_pkg::SCORE_W-1:0]  score_7,
    input  logic signed [csw_pkg::SCORE_W-1:0]  score_8,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [csw_pkg::CLASS_W-1:0]         best_class,
    output logic                                uncertain,
    output logic [csw_pkg::AVG_W-1:0]           best_average,
    input  logic                                cfg_we,
    input  logic [csw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int NW = $clog2(HISTORY_DEPTH+1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROT  = 2'd1;
    localparam logic [1:0] S_VOTE = 2'd2;

    localparam logic [NW-1:0] ROT_LAST = NW'(HISTORY_DEPTH - 1);

    logic [1:0]                           state_reg;
    logic [NW-1:0]                        rot_reg;
    logic signed [csw_pkg::SCORE_W-1:0]   offset_reg;
    logic [csw_pkg::SCALE_W-1:0]          scale_reg;
    logic [csw_pkg::WIN_W-1:0]            window_reg;
    logic [csw_pkg::LEVEL_W-1:0]          level_reg;
    logic                                 out_valid_reg;
    logic [csw_pkg::CLASS_W-1:0]          best_class_reg;
    logic                                 uncertain_reg;
    logic [csw_pkg::AVG_W-1:0]            best_average_reg;

    logic                                 in_beat;
    logic                                 load;
    logic [NW-1:0]                        n_eff;
    logic signed [csw_pkg::SCORE_W-1:0]   score_arr [csw_pkg::CLASS_COUNT];
    csw_pkg::diff_vec_t                   new_vec;
    csw_pkg::diff_vec_t                   cell_data [HISTORY_DEPTH];
    csw_pkg::cell_ctrl_t                  cell_ctrl;
    csw_pkg::vote_ctrl_t                  vote_ctrl;
    csw_pkg::vote_res_t                   vote_res;

    assign in_ready = state_reg == S_IDLE;
    assign in_beat  = in_valid && in_ready;
    assign load     = state_reg == S_VOTE && vote_res.done && (!out_valid_reg || out_ready);

    // window length clamped to 1 .. HISTORY_DEPTH
    always_comb
    begin
        priority if (window_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(window_reg) > HISTORY_DEPTH)
        begin
            n_eff = NW'(HISTORY_DEPTH);
        end
        else
        begin
            n_eff = NW'(window_reg);
        end
    end

    assign score_arr[0] = score_0;
    assign score_arr[1] = score_1;
    assign score_arr[2] = score_2;
    assign score_arr[3] = score_3;
    assign score_arr[4] = score_4;
    assign score_arr[5] = score_5;
    assign score_arr[6] = score_6;
    assign score_arr[7] = score_7;
    assign score_arr[8] = score_8;

    always_comb
    begin
        for (int c = 0; c < csw_pkg::CLASS_COUNT; c++)
        begin
            new_vec[c] = csw_pkg::DIFF_W'(score_arr[c]) - csw_pkg::DIFF_W'(offset_reg);
        end
    end

    assign cell_ctrl.push   = in_beat;
    assign cell_ctrl.rotate = state_reg == S_ROT;

    assign vote_ctrl.acc_clear = in_beat;
    assign vote_ctrl.acc_en    = state_reg == S_ROT && rot_reg < n_eff;
    assign vote_ctrl.start     = state_reg == S_ROT && rot_reg == ROT_LAST;

    // history ring: newest entry in cell 0, one turn walks every slot past cell 0
    for (genvar k = 0; k < HISTORY_DEPTH; k++)
    begin : g_cell
        csw_pkg::diff_vec_t push_src;
        if (k == 0)
        begin : g_head
            assign push_src = new_vec;
        end
        else
        begin : g_body
            assign push_src = cell_data[k-1];
        end
        csw_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .push_in (push_src),
            .rot_in  (cell_data[(k+1) % HISTORY_DEPTH]),
            .data    (cell_data[k])
        );
    end

    csw_vote #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_vote (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (vote_ctrl),
        .acc_data (cell_data[0]),
        .n_eff    (n_eff),
        .scale    (scale_reg),
        .level    (level_reg),
        .res      (vote_res)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rot_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        state_reg <= S_ROT;
                        rot_reg   <= '0;
                    end
                end
                S_ROT:
                begin
                    rot_reg <= rot_reg + NW'(1);
                    if (rot_reg == ROT_LAST)
                    begin
                        state_reg <= S_VOTE;
                    end
                end
                S_VOTE:
                begin
                    if (load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= csw_pkg::OFFSET_RESET;
            scale_reg  <= csw_pkg::SCALE_RESET;
            window_reg <= csw_pkg::WINDOW_RESET;
            level_reg  <= csw_pkg::LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                csw_pkg::REG_OFFSET: offset_reg <= $signed(cfg_data[csw_pkg::SCORE_W-1:0]);
                csw_pkg::REG_SCALE:  scale_reg  <= cfg_data[csw_pkg::SCALE_W-1:0];
                csw_pkg::REG_WINDOW: window_reg <= cfg_data[csw_pkg::WIN_W-1:0];
                csw_pkg::REG_LEVEL:  level_reg  <= cfg_data[csw_pkg::LEVEL_W-1:0];
                default:             offset_reg <= offset_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            best_class_reg   <= vote_res.best_class;
            uncertain_reg    <= vote_res.uncertain;
            best_average_reg <= vote_res.best_average;
        end
    end

    assign out_valid    = out_valid_reg;
    assign best_class   = best_class_reg;
    assign uncertain    = uncertain_reg;
    assign best_average = best_average_reg;

endmodule

FILE: rtl/csw_checker.sv
// port-level checker for the class score window vote block and its bind
`include "class_score_window_vote_assert.svh"

module csw_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [csw_pkg::CLASS_W-1:0]         best_class,
    input logic                                uncertain,
    input logic [csw_pkg::AVG_W-1:0]           best_average
);

    localparam logic [csw_pkg::CLASS_W-1:0] LAST_CLASS =
        csw_pkg::CLASS_W'(csw_pkg::CLASS_COUNT - 1);

    logic [csw_pkg::CLASS_W+csw_pkg::AVG_W:0] out_payload;

    assign out_payload = {best_class, uncertain, best_average};

    // stalled result beat stays offered
    `CSW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // stalled result beat keeps its payload
    `CSW_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_payload))

    // an accepted item keeps the input closed while it is worked on
    `CSW_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)

    // winning class is always a real class
    `CSW_ASSERT_NOW(a_class_range, clk, rst_n, out_valid, best_class <= LAST_CLASS)

endmodule

bind class_score_window_vote csw_checker u_csw_checker (.*);
